// File: rtl/rcd_pkg.sv
`default_nettype none

package rcd_pkg;

  // Field widths of one beat on each channel.
  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ClassWidth = 3;
  localparam int unsigned OpWidth    = 7;

  typedef logic [OpWidth-1:0]    alu_op_t;
  typedef logic [ClassWidth-1:0] alu_class_t;
  typedef logic [6:0]            opcode_t;

  // Major opcodes.
  localparam opcode_t OPC_OP        = 7'b0110011;
  localparam opcode_t OPC_OP_IMM    = 7'b0010011;
  localparam opcode_t OPC_LOAD      = 7'b0000011;
  localparam opcode_t OPC_LOAD_FP   = 7'b0000111;
  localparam opcode_t OPC_STORE     = 7'b0100011;
  localparam opcode_t OPC_STORE_FP  = 7'b0100111;
  localparam opcode_t OPC_BRANCH    = 7'b1100011;
  localparam opcode_t OPC_LUI       = 7'b0110111;
  localparam opcode_t OPC_JALR      = 7'b1100111;
  localparam opcode_t OPC_AUIPC     = 7'b0010111;
  localparam opcode_t OPC_JAL       = 7'b1101111;
  localparam opcode_t OPC_OP_32     = 7'b0111011;
  localparam opcode_t OPC_OP_IMM_32 = 7'b0011011;
  localparam opcode_t OPC_OP_FP     = 7'b1010011;
  localparam opcode_t OPC_MADD      = 7'b1000011;
  localparam opcode_t OPC_MSUB      = 7'b1000111;
  localparam opcode_t OPC_NMSUB     = 7'b1001011;
  localparam opcode_t OPC_NMADD     = 7'b1001111;

  // funct7 values that select the M extension and the alternate forms.
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  // Upper immediate bits 31:26 that mark SRAI.
  localparam logic [5:0] F6_SRAI   = 6'b010000;

  // ALU classes.
  localparam alu_class_t CLASS_ADD   = 3'd0;
  localparam alu_class_t CLASS_IMM   = 3'd1;
  localparam alu_class_t CLASS_REG   = 3'd2;
  localparam alu_class_t CLASS_FP    = 3'd3;
  localparam alu_class_t CLASS_FMA   = 3'd4;

  // ALU operation codes.
  localparam alu_op_t OP_NONE  = 7'd0;
  localparam alu_op_t OP_ADD   = 7'd1;
  localparam alu_op_t OP_SUB   = 7'd2;
  localparam alu_op_t OP_SLL   = 7'd3;
  localparam alu_op_t OP_SLT   = 7'd4;
  localparam alu_op_t OP_SLTU  = 7'd5;
  localparam alu_op_t OP_XOR   = 7'd6;
  localparam alu_op_t OP_SRL   = 7'd7;
  localparam alu_op_t OP_SRA   = 7'd8;
  localparam alu_op_t OP_OR    = 7'd9;
  localparam alu_op_t OP_AND   = 7'd10;
  localparam alu_op_t OP_MUL   = 7'd11;
  localparam alu_op_t OP_ADDW  = 7'd19;
  localparam alu_op_t OP_SUBW  = 7'd20;
  localparam alu_op_t OP_SLLW  = 7'd21;
  localparam alu_op_t OP_SRLW  = 7'd22;
  localparam alu_op_t OP_SRAW  = 7'd23;
  localparam alu_op_t OP_MULW  = 7'd24;
  localparam alu_op_t OP_DIVW  = 7'd25;
  localparam alu_op_t OP_DIVUW = 7'd26;
  localparam alu_op_t OP_REMW  = 7'd27;
  localparam alu_op_t OP_REMUW = 7'd28;
  localparam alu_op_t OP_FP_S_BASE  = 7'd29;
  localparam alu_op_t OP_FP_D_SHIFT = 7'd24;
  localparam alu_op_t OP_FMA_BASE   = 7'd77;
  localparam alu_op_t OP_LAST       = 7'd84;

  // One registered result beat.
  typedef struct packed {
    logic       reg_write;
    logic       alu_source_imm;
    logic       mem_to_reg;
    logic       mem_read;
    logic       mem_write;
    logic       is_branch;
    alu_class_t alu_class;
    alu_op_t    alu_operation;
  } rcd_result_t;

  // Base integer operation selected by funct3.
  function automatic alu_op_t rtype_base(input logic [2:0] f3);
    alu_op_t op;
    unique case (f3)
      3'd0: op = OP_ADD;
      3'd1: op = OP_SLL;
      3'd2: op = OP_SLT;
      3'd3: op = OP_SLTU;
      3'd4: op = OP_XOR;
      3'd5: op = OP_SRL;
      3'd6: op = OP_OR;
      default: op = OP_AND;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rcd_instr_if.sv
`default_nettype none

interface rcd_instr_if;
  import rcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [InstrWidth-1:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

`default_nettype wire

// File: rtl/rcd_result_if.sv
`default_nettype none

interface rcd_result_if;
  import rcd_pkg::*;

  logic       valid;
  logic       ready;
  logic       reg_write;
  logic       alu_source_imm;
  logic       mem_to_reg;
  logic       mem_read;
  logic       mem_write;
  logic       is_branch;
  alu_class_t alu_class;
  alu_op_t    alu_operation;

  modport source (
    output valid, output reg_write, output alu_source_imm, output mem_to_reg,
    output mem_read, output mem_write, output is_branch, output alu_class,
    output alu_operation, input ready
  );
  modport sink (
    input valid, input reg_write, input alu_source_imm, input mem_to_reg,
    input mem_read, input mem_write, input is_branch, input alu_class,
    input alu_operation, output ready
  );
endinterface

`default_nettype wire

// File: rtl/riscv_control_decoder.sv
// Main control and ALU operation decode for RV64IMFD instructions.
//
// The instr channel takes one 32-bit instruction per beat. The result channel
// gives one beat per instruction, in order: the six control flags, the ALU
// class (0 to 4) and the ALU operation code (0 means none).
//
// Inside are two registers: the instruction register, then the result
// register, with the table decode between them. An accepted instruction is
// held in the instruction register, and its decoded result is registered in
// the result register, from which its result beat is offered. One
// instruction is accepted every cycle while the receiver keeps up; both
// stages move forward on the same edge.
//
// When the receiver stalls, the result register holds its beat; the
// instruction register still fills, so one more instruction is taken before
// instr.ready drops. Ready returns in the same cycle that result.ready rises.
// Synchronous reset empties both stages; no beat is offered after reset
// until a new instruction is accepted.
`default_nettype none

module riscv_control_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  rcd_instr_if.sink   instr,
  rcd_result_if.source result
);
  import rcd_pkg::*;

  logic [InstrWidth-1:0] instr_reg;
  logic                  instr_valid;
  rcd_result_t           result_reg;
  rcd_result_t           result_next;
  logic                  result_valid;
  logic                  result_advance;
  logic                  instr_take;
  alu_op_t               alu_op;

  // Stage handshakes: each stage moves when the one after it has room.
  assign result_advance = !result_valid || result.ready;
  assign instr.ready    = !instr_valid || result_advance;
  assign instr_take     = instr.valid && instr.ready;

  // Instruction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      instr_valid <= 1'b0;
    end else if (instr.ready) begin
      instr_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_take) begin
      instr_reg <= instr.instruction_word;
    end
  end

  // Instruction fields.
  opcode_t    opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] f5;
  logic [1:0] f2;
  logic [5:0] fp_group;
  logic       fp_double;

  assign opc       = instr_reg[6:0];
  assign f3        = instr_reg[14:12];
  assign f7        = instr_reg[31:25];
  assign f5        = instr_reg[24:20];
  assign f2        = instr_reg[26:25];
  assign fp_group  = f7[6:1];
  assign fp_double = f7[0];

  // Control flags and ALU class from the major opcode.
  always_comb begin
    result_next = '0;
    unique case (opc)
      OPC_OP: begin
        result_next.reg_write = 1'b1;
        result_next.alu_class = CLASS_REG;
      end
      OPC_OP_IMM: begin
        result_next.reg_write      = 1'b1;
        result_next.alu_source_imm = 1'b1;
        result_next.alu_class      = CLASS_IMM;
      end
      OPC_LOAD, OPC_LOAD_FP: begin
        result_next.reg_write      = 1'b1;
        result_next.alu_source_imm = 1'b1;
        result_next.mem_to_reg     = 1'b1;
        result_next.mem_read       = 1'b1;
      end
      OPC_STORE, OPC_STORE_FP: begin
        result_next.alu_source_imm = 1'b1;
        result_next.mem_write      = 1'b1;
      end
      OPC_BRANCH: begin
        result_next.is_branch = 1'b1;
        result_next.alu_class = CLASS_IMM;
      end
      OPC_LUI, OPC_JALR: begin
        result_next.reg_write      = 1'b1;
        result_next.alu_source_imm = 1'b1;
      end
      OPC_AUIPC, OPC_JAL: begin
        result_next.reg_write = 1'b1;
      end
      OPC_OP_IMM_32: begin
        result_next.reg_write      = 1'b1;
        result_next.alu_source_imm = 1'b1;
        result_next.alu_class      = CLASS_REG;
      end
      OPC_OP_32: begin
        result_next.reg_write = 1'b1;
        result_next.alu_class = CLASS_REG;
      end
      OPC_OP_FP: begin
        result_next.reg_write = 1'b1;
        result_next.alu_class = CLASS_FP;
      end
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
        result_next.reg_write = 1'b1;
        result_next.alu_class = CLASS_FMA;
      end
      default: begin
      end
    endcase
    result_next.alu_operation = alu_op;
  end

  // Integer register decode. A W combination that is not listed falls
  // through to the 64-bit table.
  alu_op_t reg_op;
  logic    w_hit;
  alu_op_t w_op;

  always_comb begin
    w_hit = 1'b0;
    w_op  = OP_NONE;
    if (opc == OPC_OP_32 || opc == OPC_OP_IMM_32) begin
      unique case (f3)
        3'd0: begin
          w_hit = 1'b1;
          if (opc == OPC_OP_IMM_32) begin
            w_op = OP_ADDW;
          end else if (f7 == F7_MULDIV) begin
            w_op = OP_MULW;
          end else if (f7 == F7_ALT) begin
            w_op = OP_SUBW;
          end else begin
            w_op = OP_ADDW;
          end
        end
        3'd1: begin
          w_hit = 1'b1;
          w_op  = OP_SLLW;
        end
        3'd4: begin
          w_hit = (f7 == F7_MULDIV);
          w_op  = OP_DIVW;
        end
        3'd5: begin
          w_hit = 1'b1;
          if (f7 == F7_MULDIV) begin
            w_op = OP_DIVUW;
          end else if (f7 == F7_ALT) begin
            w_op = OP_SRAW;
          end else begin
            w_op = OP_SRLW;
          end
        end
        3'd6: begin
          w_hit = (f7 == F7_MULDIV);
          w_op  = OP_REMW;
        end
        3'd7: begin
          w_hit = (f7 == F7_MULDIV);
          w_op  = OP_REMUW;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (w_hit) begin
      reg_op = w_op;
    end else if (f7 == F7_MULDIV) begin
      reg_op = OP_MUL + alu_op_t'(f3);
    end else if (f7 == F7_ALT && f3 == 3'd0) begin
      reg_op = OP_SUB;
    end else if (f7 == F7_ALT && f3 == 3'd5) begin
      reg_op = OP_SRA;
    end else begin
      reg_op = rtype_base(f3);
    end
  end

  // Branch and immediate decode.
  alu_op_t imm_op;

  always_comb begin
    if (opc == OPC_BRANCH) begin
      unique case (f3)
        3'd0, 3'd1: imm_op = OP_SUB;
        3'd4, 3'd5: imm_op = OP_SLT;
        3'd6, 3'd7: imm_op = OP_SLTU;
        default:    imm_op = OP_NONE;
      endcase
    end else if (f3 == 3'd5) begin
      imm_op = (instr_reg[31:26] == F6_SRAI) ? OP_SRA : OP_SRL;
    end else begin
      imm_op = rtype_base(f3);
    end
  end

  // Floating-point decode: index into the single-precision list, then
  // offset for double precision.
  logic [4:0] fp_index;
  logic       fp_hit;
  alu_op_t    fp_op;

  always_comb begin
    fp_index = '0;
    fp_hit   = 1'b0;
    unique case (fp_group)
      6'h00: begin fp_hit = 1'b1; fp_index = 5'd0; end
      6'h02: begin fp_hit = 1'b1; fp_index = 5'd1; end
      6'h04: begin fp_hit = 1'b1; fp_index = 5'd2; end
      6'h06: begin fp_hit = 1'b1; fp_index = 5'd3; end
      6'h16: begin fp_hit = (f5 == 5'd0); fp_index = 5'd4; end
      6'h08: begin
        fp_hit   = (f3 <= 3'd2);
        fp_index = 5'd5 + {2'b00, f3};
      end
      6'h0A: begin
        fp_hit   = (f3 <= 3'd1);
        fp_index = 5'd8 + {2'b00, f3};
      end
      6'h28: begin
        fp_hit   = (f3 <= 3'd2);
        fp_index = 5'd12 - {2'b00, f3};
      end
      6'h30: begin
        fp_hit   = (f5 <= 5'd3);
        fp_index = 5'd13 + {3'b000, f5[1:0]};
      end
      6'h34: begin
        fp_hit   = (f5 <= 5'd3);
        fp_index = 5'd17 + {3'b000, f5[1:0]};
      end
      6'h38: begin
        fp_hit   = (f3 <= 3'd1);
        fp_index = 5'd22 - {4'b0000, f3[0]};
      end
      6'h3C: begin fp_hit = 1'b1; fp_index = 5'd23; end
      default: begin
      end
    endcase
    fp_op = OP_FP_S_BASE + {2'b00, fp_index} + (fp_double ? OP_FP_D_SHIFT : OP_NONE);
  end

  // Fused multiply-add: the opcode picks the form, funct2 the precision.
  alu_op_t fma_op;
  assign fma_op = OP_FMA_BASE + {5'b00000, opc[3:2]} + ((f2 != 2'b00) ? 7'd4 : 7'd0);

  // Final operation select by class.
  always_comb begin
    unique case (opc)
      OPC_OP, OPC_OP_32, OPC_OP_IMM_32:             alu_op = reg_op;
      OPC_OP_IMM, OPC_BRANCH:                       alu_op = imm_op;
      OPC_OP_FP:                                    alu_op = fp_hit ? fp_op : OP_NONE;
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD:     alu_op = fma_op;
      default:                                      alu_op = OP_ADD;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_advance) begin
      result_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_advance && instr_valid) begin
      result_reg <= result_next;
    end
  end

  assign result.valid          = result_valid;
  assign result.reg_write      = result_reg.reg_write;
  assign result.alu_source_imm = result_reg.alu_source_imm;
  assign result.mem_to_reg     = result_reg.mem_to_reg;
  assign result.mem_read       = result_reg.mem_read;
  assign result.mem_write      = result_reg.mem_write;
  assign result.is_branch      = result_reg.is_branch;
  assign result.alu_class      = result_reg.alu_class;
  assign result.alu_operation  = result_reg.alu_operation;

  // A full pipeline with a stalled receiver must refuse new instructions.
  a_full_blocks : assert property (@(posedge clk) disable iff (rst)
    (instr_valid && result_valid && !result.ready) |-> !instr.ready)
    else $error("instruction accepted while both stages are full and stalled");

  // An unstalled instruction moves to the result register at the next edge.
  a_moves_on : assert property (@(posedge clk) disable iff (rst)
    (instr_valid && result_advance) |=> result_valid)
    else $error("decoded instruction lost between stages");

  // Operation codes stay within the defined range.
  a_op_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_reg.alu_operation <= OP_LAST))
    else $error("operation code out of range");

  // Loads always write back from memory.
  a_load_flags : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_reg.mem_read) |->
      (result_reg.mem_to_reg && result_reg.reg_write && !result_reg.mem_write))
    else $error("inconsistent load control flags");

  // The FMA class only gives FMA operation codes.
  a_fma_ops : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_reg.alu_class == CLASS_FMA) |->
      (result_reg.alu_operation >= OP_FMA_BASE))
    else $error("FMA class with a non-FMA operation");

endmodule

`default_nettype wire
